/* design/peu_pkg.sv */
// Package for the particle Euler update block: payload types, register
// indexes, reset values, fixed-point constants and saturation helpers.
// No dependencies.
`default_nettype none

package peu_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;
   typedef logic signed [31:0]    q16_16_type;
   typedef logic signed [15:0]    fix16_type;
   typedef logic [23:0]           age_type;

   // register indexes
   localparam csr_idx_type REG_FRAME_DT   = 3'd0;
   localparam csr_idx_type REG_LIFETIME   = 3'd1;
   localparam csr_idx_type REG_GRAVITY    = 3'd2;
   localparam csr_idx_type REG_DRAG       = 3'd3;
   localparam csr_idx_type REG_BOUNCE     = 3'd4;
   localparam csr_idx_type REG_COLLISION  = 3'd5;
   localparam csr_idx_type REG_SIZE_GROW  = 3'd6;
   localparam csr_idx_type REG_COLOR_FADE = 3'd7;

   // reset values
   localparam logic [23:0] LIFETIME_RST = 24'd327680;      // 5.0 s
   localparam logic [47:0] GRAVITY_RST  = 48'h0000_F631_0000; // y = -9.81

   // 0.8 in Q0.16 and 0.01 in Q16.16
   localparam logic signed [17:0] EIGHT_TENTHS_Q16 = 18'sd52429;
   localparam logic signed [31:0] GROUND_Y_Q16     = 32'sd655;

   function automatic logic [31:0] sat_to32(input logic [35:0] x);
      if (x[35:31] == 5'b00000 || x[35:31] == 5'b11111) begin
         return x[31:0];
      end else if (x[35]) begin
         return 32'h8000_0000;
      end else begin
         return 32'h7FFF_FFFF;
      end
   endfunction

   function automatic logic [15:0] sat_to16(input logic [17:0] x);
      if (x[17:15] == 3'b000 || x[17:15] == 3'b111) begin
         return x[15:0];
      end else if (x[17]) begin
         return 16'h8000;
      end else begin
         return 16'h7FFF;
      end
   endfunction

endpackage

`default_nettype wire

/* design/particle_euler_update.sv */
// Top level of the particle Euler update: configuration registers and a
// six-register pipeline that advances one particle per clock unless stalled.
// Depends on peu_pkg.
//
//   channel  direction  handshake            beat
//   req_     in         req_valid/req_ready  one particle state
//   rsp_     out        rsp_valid/rsp_ready  alive flag and next particle state
//   csr_     in         csr_wr_en            one register write, no wait
//
// A particle accepted into stage 1 moves through stages 2 to 5 and the output
// stage to rsp_; one can enter every cycle unless rsp_ stalls. The wide
// products (velocity times drag*dt, the rescale by 2^32 - drag*dt, velocity
// times dt) each get a stage of their own. Reset clears the valid bits and
// loads the register reset values. Each stage holds while the one after it is
// full and stalled, so bubbles collapse and a stall drops or repeats nothing.
`default_nettype none

module particle_euler_update (
   input  wire logic               clock,
   input  wire logic               reset,
   // input channel
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire peu_pkg::q16_16_type req_in_pos_x,
   input  wire peu_pkg::q16_16_type req_in_pos_y,
   input  wire peu_pkg::q16_16_type req_in_pos_z,
   input  wire peu_pkg::q16_16_type req_in_vel_x,
   input  wire peu_pkg::q16_16_type req_in_vel_y,
   input  wire peu_pkg::q16_16_type req_in_vel_z,
   input  wire peu_pkg::fix16_type  req_in_extent,
   input  wire peu_pkg::fix16_type  req_in_red,
   input  wire peu_pkg::fix16_type  req_in_green,
   input  wire peu_pkg::fix16_type  req_in_blue,
   input  wire peu_pkg::fix16_type  req_in_alpha,
   input  wire peu_pkg::age_type    req_in_age,
   // result channel
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_alive,
   output peu_pkg::q16_16_type     rsp_out_pos_x,
   output peu_pkg::q16_16_type     rsp_out_pos_y,
   output peu_pkg::q16_16_type     rsp_out_pos_z,
   output peu_pkg::q16_16_type     rsp_out_vel_x,
   output peu_pkg::q16_16_type     rsp_out_vel_y,
   output peu_pkg::q16_16_type     rsp_out_vel_z,
   output peu_pkg::fix16_type      rsp_out_extent,
   output peu_pkg::fix16_type      rsp_out_red,
   output peu_pkg::fix16_type      rsp_out_green,
   output peu_pkg::fix16_type      rsp_out_blue,
   output peu_pkg::fix16_type      rsp_out_alpha,
   // configuration
   input  wire logic               csr_wr_en,
   input  wire peu_pkg::csr_idx_type  csr_idx,
   input  wire peu_pkg::csr_data_type csr_wdata
);
   import peu_pkg::*;

   // ---------------------------------------------------------------------
   // Stage payloads
   // ---------------------------------------------------------------------
   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [2:0][31:0] vel;
      logic [15:0]      ext;
      logic [3:0][15:0] col;   // r, g, b, a
      logic [23:0]      age;
   } s1_type;

   typedef struct packed {
      logic             alive;
      logic [2:0][31:0] pos;
      logic [2:0][31:0] vel;   // velocity with gravity
      logic [15:0]      ext;   // final size
      logic [3:0][15:0] col;   // final color
   } s2_type;

   typedef struct packed {
      logic             alive;
      logic [2:0][31:0] pos;
      logic [2:0][31:0] vel;
      logic [2:0][64:0] prod;  // velocity times drag*dt
      logic [15:0]      ext;
      logic [3:0][15:0] col;
   } s3_type;

   typedef struct packed {
      logic             alive;
      logic [2:0][31:0] pos;
      logic [2:0][31:0] vel;   // velocity after drag
      logic [15:0]      ext;
      logic [3:0][15:0] col;
   } s4_type;

   typedef struct packed {
      logic             alive;
      logic [2:0][31:0] pos;
      logic [2:0][31:0] vel;
      logic [2:0][48:0] step;  // velocity times dt
      logic [48:0]      vy_bnc; // y velocity times bounce factor
      logic [49:0]      vx_bnc; // x velocity times 0.8
      logic [15:0]      ext;
      logic [3:0][15:0] col;
   } s5_type;

   typedef struct packed {
      logic             alive;
      logic [2:0][31:0] pos;
      logic [2:0][31:0] vel;
      logic [15:0]      ext;
      logic [3:0][15:0] col;
   } out_type;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [15:0] dt_ff;
   logic [23:0] life_ff;
   logic [47:0] grav_ff;
   logic [15:0] drag_ff;
   logic [15:0] bnc_ff;
   logic        coll_ff;
   logic [15:0] size_rate_ff;
   logic [63:0] fade_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff        <= '0;
         life_ff      <= LIFETIME_RST;
         grav_ff      <= GRAVITY_RST;
         drag_ff      <= '0;
         bnc_ff       <= '0;
         coll_ff      <= 1'b0;
         size_rate_ff <= '0;
         fade_ff      <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_idx)
            REG_FRAME_DT:   dt_ff        <= csr_wdata[15:0];
            REG_LIFETIME:   life_ff      <= csr_wdata[23:0];
            REG_GRAVITY:    grav_ff      <= csr_wdata[47:0];
            REG_DRAG:       drag_ff      <= csr_wdata[15:0];
            REG_BOUNCE:     bnc_ff       <= csr_wdata[15:0];
            REG_COLLISION:  coll_ff      <= csr_wdata[0];
            REG_SIZE_GROW:  size_rate_ff <= csr_wdata[15:0];
            REG_COLOR_FADE: fade_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Per-frame terms: depend on registers only, so form them once and
   // register them. They settle in the cycle after a write, before any
   // particle accepted afterwards reaches the stage that reads them.
   // ---------------------------------------------------------------------
   logic signed [32:0] gprod [3];
   logic [32:0]        gtmp  [3];
   logic [24:0]        gdt_in [3];
   logic [24:0]        gdt_ff [3];   // rnd(g*dt, 8)
   logic [31:0]        dd_in, dd_ff; // drag*dt
   logic signed [32:0] sprod;
   logic [32:0]        stmp;
   logic [16:0]        sdt_in, sdt_ff;
   logic signed [32:0] cprod [4];
   logic [32:0]        ctmp  [4];
   logic [16:0]        cdt_in [4];
   logic [16:0]        cdt_ff [4];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         gprod[k]  = $signed(grav_ff[16*k +: 16]) * $signed({1'b0, dt_ff});
         gtmp[k]   = gprod[k] + 33'd128;
         gdt_in[k] = gtmp[k][32:8];
      end
      dd_in  = {16'h0, drag_ff} * {16'h0, dt_ff};
      sprod  = $signed(size_rate_ff) * $signed({1'b0, dt_ff});
      stmp   = sprod + 33'd32768;
      sdt_in = stmp[32:16];
      for (int k = 0; k < 4; k++) begin
         cprod[k]  = $signed(fade_ff[16*k +: 16]) * $signed({1'b0, dt_ff});
         ctmp[k]   = cprod[k] + 33'd32768;
         cdt_in[k] = ctmp[k][32:16];
      end
   end

   always_ff @(posedge clock) begin
      gdt_ff <= gdt_in;
      dd_ff  <= dd_in;
      sdt_ff <= sdt_in;
      cdt_ff <= cdt_in;
   end

   // ---------------------------------------------------------------------
   // Pipeline control: a stage loads when it is empty or the next one loads
   // ---------------------------------------------------------------------
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff, out_vld_ff;
   logic ld1, ld2, ld3, ld4, ld5, ld_out;

   assign ld_out    = !out_vld_ff || rsp_ready;
   assign ld5       = !s5_vld_ff  || ld_out;
   assign ld4       = !s4_vld_ff  || ld5;
   assign ld3       = !s3_vld_ff  || ld4;
   assign ld2       = !s2_vld_ff  || ld3;
   assign ld1       = !s1_vld_ff  || ld2;
   assign req_ready = ld1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         s5_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (ld1)    s1_vld_ff  <= req_valid;
         if (ld2)    s2_vld_ff  <= s1_vld_ff;
         if (ld3)    s3_vld_ff  <= s2_vld_ff;
         if (ld4)    s4_vld_ff  <= s3_vld_ff;
         if (ld5)    s5_vld_ff  <= s4_vld_ff;
         if (ld_out) out_vld_ff <= s5_vld_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: capture the beat
   // ---------------------------------------------------------------------
   s1_type s1_in, s1_ff;

   always_comb begin
      s1_in.pos = {req_in_pos_z, req_in_pos_y, req_in_pos_x};
      s1_in.vel = {req_in_vel_z, req_in_vel_y, req_in_vel_x};
      s1_in.ext = req_in_extent;
      s1_in.col = {req_in_alpha, req_in_blue, req_in_green, req_in_red};
      s1_in.age = req_in_age;
   end

   always_ff @(posedge clock) begin
      if (ld1) s1_ff <= s1_in;
   end

   // ---------------------------------------------------------------------
   // Stage 2: death check, gravity, size and color
   // ---------------------------------------------------------------------
   s2_type      s2_in, s2_ff;
   logic [24:0] age_sum;
   logic [32:0] vsum [3];
   logic [17:0] esum;
   logic [17:0] csum [4];

   always_comb begin
      // age sum keeps its carry: no wrap, no saturation
      age_sum     = {1'b0, s1_ff.age} + {9'h0, dt_ff};
      s2_in.alive = (age_sum < {1'b0, life_ff}) &&
                    !s1_ff.col[3][15] && (s1_ff.col[3] != 16'h0);
      s2_in.pos   = s1_ff.pos;
      for (int k = 0; k < 3; k++) begin
         vsum[k]      = {s1_ff.vel[k][31], s1_ff.vel[k]} +
                        {{8{gdt_ff[k][24]}}, gdt_ff[k]};
         s2_in.vel[k] = sat_to32({{3{vsum[k][32]}}, vsum[k]});
      end
      esum      = {{2{s1_ff.ext[15]}}, s1_ff.ext} + {sdt_ff[16], sdt_ff};
      s2_in.ext = sat_to16(esum);
      for (int k = 0; k < 4; k++) begin
         csum[k]      = {{2{s1_ff.col[k][15]}}, s1_ff.col[k]} +
                        {cdt_ff[k][16], cdt_ff[k]};
         s2_in.col[k] = sat_to16(csum[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (ld2) s2_ff <= s2_in;
   end

   // ---------------------------------------------------------------------
   // Stage 3: velocity times drag*dt
   // ---------------------------------------------------------------------
   s3_type             s3_in, s3_ff;
   logic signed [64:0] mprod [3];

   always_comb begin
      s3_in.alive = s2_ff.alive;
      s3_in.pos   = s2_ff.pos;
      s3_in.vel   = s2_ff.vel;
      s3_in.ext   = s2_ff.ext;
      s3_in.col   = s2_ff.col;
      for (int k = 0; k < 3; k++) begin
         mprod[k]      = $signed(s2_ff.vel[k]) * $signed({1'b0, dd_ff});
         s3_in.prod[k] = mprod[k];
      end
   end

   always_ff @(posedge clock) begin
      if (ld3) s3_ff <= s3_in;
   end

   // ---------------------------------------------------------------------
   // Stage 4: v * (2^32 - drag*dt), rounded back to Q16.16
   // ---------------------------------------------------------------------
   s4_type      s4_in, s4_ff;
   logic [65:0] dtmp [3];

   always_comb begin
      s4_in.alive = s3_ff.alive;
      s4_in.pos   = s3_ff.pos;
      s4_in.ext   = s3_ff.ext;
      s4_in.col   = s3_ff.col;
      for (int k = 0; k < 3; k++) begin
         dtmp[k] = {{2{s3_ff.vel[k][31]}}, s3_ff.vel[k], 32'h0} -
                   {s3_ff.prod[k][64], s3_ff.prod[k]} + 66'h8000_0000;
         s4_in.vel[k] = sat_to32({{2{dtmp[k][65]}}, dtmp[k][65:32]});
      end
   end

   always_ff @(posedge clock) begin
      if (ld4) s4_ff <= s4_in;
   end

   // ---------------------------------------------------------------------
   // Stage 5: position step and both bounce products
   // ---------------------------------------------------------------------
   s5_type             s5_in, s5_ff;
   logic signed [48:0] sprd [3];
   logic signed [48:0] byprd;
   logic signed [49:0] bxprd;

   always_comb begin
      s5_in.alive = s4_ff.alive;
      s5_in.pos   = s4_ff.pos;
      s5_in.vel   = s4_ff.vel;
      s5_in.ext   = s4_ff.ext;
      s5_in.col   = s4_ff.col;
      for (int k = 0; k < 3; k++) begin
         sprd[k]       = $signed(s4_ff.vel[k]) * $signed({1'b0, dt_ff});
         s5_in.step[k] = sprd[k];
      end
      byprd        = $signed(s4_ff.vel[1]) * $signed({1'b0, bnc_ff});
      bxprd        = $signed(s4_ff.vel[0]) * EIGHT_TENTHS_Q16;
      s5_in.vy_bnc = byprd;
      s5_in.vx_bnc = bxprd;
   end

   always_ff @(posedge clock) begin
      if (ld5) s5_ff <= s5_in;
   end

   // ---------------------------------------------------------------------
   // Output stage: new position, ground bounce, zero a dead particle
   // ---------------------------------------------------------------------
   out_type     out_in, out_ff;
   logic [48:0] stmp5 [3];
   logic [35:0] psum  [3];
   logic [31:0] pnew  [3];
   logic [49:0] vytmp;
   logic [49:0] vxtmp;
   logic [31:0] vy_b, vx_b;
   logic        bounce;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         stmp5[k] = s5_ff.step[k] + 49'h8000;
         psum[k]  = {{4{s5_ff.pos[k][31]}}, s5_ff.pos[k]} +
                    {{3{stmp5[k][48]}}, stmp5[k][48:16]};
         pnew[k]  = sat_to32(psum[k]);
      end
      // negate before rounding so ties still go toward plus infinity
      vytmp  = 50'h0 - {s5_ff.vy_bnc[48], s5_ff.vy_bnc} + 50'h2000;
      vy_b   = sat_to32(vytmp[49:14]);
      vxtmp  = s5_ff.vx_bnc + 50'h8000;
      vx_b   = sat_to32({{2{vxtmp[49]}}, vxtmp[49:16]});
      bounce = coll_ff && pnew[1][31];

      out_in = '0;
      if (s5_ff.alive) begin
         out_in.alive  = 1'b1;
         out_in.pos[0] = pnew[0];
         out_in.pos[1] = bounce ? GROUND_Y_Q16 : pnew[1];
         out_in.pos[2] = pnew[2];
         out_in.vel[0] = bounce ? vx_b : s5_ff.vel[0];
         out_in.vel[1] = bounce ? vy_b : s5_ff.vel[1];
         out_in.vel[2] = s5_ff.vel[2];
         out_in.ext    = s5_ff.ext;
         out_in.col    = s5_ff.col;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_out) out_ff <= out_in;
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_alive      = out_ff.alive;
   assign rsp_out_pos_x  = out_ff.pos[0];
   assign rsp_out_pos_y  = out_ff.pos[1];
   assign rsp_out_pos_z  = out_ff.pos[2];
   assign rsp_out_vel_x  = out_ff.vel[0];
   assign rsp_out_vel_y  = out_ff.vel[1];
   assign rsp_out_vel_z  = out_ff.vel[2];
   assign rsp_out_extent = out_ff.ext;
   assign rsp_out_red    = out_ff.col[0];
   assign rsp_out_green  = out_ff.col[1];
   assign rsp_out_blue   = out_ff.col[2];
   assign rsp_out_alpha  = out_ff.col[3];

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for particle_euler_update: random and directed particle
// beats, with an in-bench fixed-point predictor of the next particle state.
// Depends on peu_pkg and the particle_euler_update RTL.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import peu_pkg::*;

   // Wide enough for the largest product (velocity times drag factor).
   typedef logic signed [95:0] wide_type;

   typedef struct packed {
      q16_16_type pos_x;
      q16_16_type pos_y;
      q16_16_type pos_z;
      q16_16_type vel_x;
      q16_16_type vel_y;
      q16_16_type vel_z;
      fix16_type  extent;
      fix16_type  red;
      fix16_type  green;
      fix16_type  blue;
      fix16_type  alpha;
      age_type    age;
   } particle_type;

   typedef struct packed {
      logic       alive;
      q16_16_type pos_x;
      q16_16_type pos_y;
      q16_16_type pos_z;
      q16_16_type vel_x;
      q16_16_type vel_y;
      q16_16_type vel_z;
      fix16_type  extent;
      fix16_type  red;
      fix16_type  green;
      fix16_type  blue;
      fix16_type  alpha;
   } particle_next_type;

   logic clock;
   logic reset = 1'b1;

   logic           req_valid = 1'b0;
   logic           req_ready;
   particle_type   beat      = '0;
   logic           rsp_valid;
   logic           rsp_ready = 1'b0;
   logic           rsp_alive;
   q16_16_type     rsp_pos_x, rsp_pos_y, rsp_pos_z;
   q16_16_type     rsp_vel_x, rsp_vel_y, rsp_vel_z;
   fix16_type      rsp_extent, rsp_red, rsp_green, rsp_blue, rsp_alpha;
   logic           csr_wr_en = 1'b0;
   csr_idx_type    csr_idx   = '0;
   csr_data_type   csr_wdata = '0;

   // Shadow copy of the frame settings, loaded with the reset values.
   logic [15:0] step_dt     = '0;
   logic [23:0] max_age     = LIFETIME_RST;
   logic [47:0] accel_xyz   = GRAVITY_RST;
   logic [15:0] drag_coef   = '0;
   logic [15:0] restitution = '0;
   logic        ground_on   = 1'b0;
   logic [15:0] grow_rate   = '0;
   logic [63:0] fade_rgba   = '0;

   particle_type      pending_particles[$];
   particle_next_type predicted_states[$];
   int unsigned       mismatches = 0;
   bit                steady     = 1'b0;   // no idling on either side while set
   particle_next_type got, want;

   particle_euler_update i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_pos_x   (beat.pos_x),
      .req_in_pos_y   (beat.pos_y),
      .req_in_pos_z   (beat.pos_z),
      .req_in_vel_x   (beat.vel_x),
      .req_in_vel_y   (beat.vel_y),
      .req_in_vel_z   (beat.vel_z),
      .req_in_extent  (beat.extent),
      .req_in_red     (beat.red),
      .req_in_green   (beat.green),
      .req_in_blue    (beat.blue),
      .req_in_alpha   (beat.alpha),
      .req_in_age     (beat.age),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_alive      (rsp_alive),
      .rsp_out_pos_x  (rsp_pos_x),
      .rsp_out_pos_y  (rsp_pos_y),
      .rsp_out_pos_z  (rsp_pos_z),
      .rsp_out_vel_x  (rsp_vel_x),
      .rsp_out_vel_y  (rsp_vel_y),
      .rsp_out_vel_z  (rsp_vel_z),
      .rsp_out_extent (rsp_extent),
      .rsp_out_red    (rsp_red),
      .rsp_out_green  (rsp_green),
      .rsp_out_blue   (rsp_blue),
      .rsp_out_alpha  (rsp_alpha),
      .csr_wr_en      (csr_wr_en),
      .csr_idx        (csr_idx),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Round to nearest, ties toward plus infinity, dropping n fraction bits.
   function automatic wide_type round_shift(wide_type x, int n);
      return (x + (wide_type'(1) <<< (n - 1))) >>> n;
   endfunction

   function automatic wide_type clamp(wide_type x, int w);
      wide_type hi, lo;
      hi = (wide_type'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (x > hi) return hi;
      if (x < lo) return lo;
      return x;
   endfunction

   // One Euler step of one particle under the current frame settings.
   function automatic particle_next_type advance_particle(particle_type s);
      particle_next_type r;
      wide_type          dt, fac, g, rate;
      wide_type          p[3], v[3], c[4];
      logic [24:0]       age_sum;
      r = '0;
      dt = wide_type'(step_dt);
      // The age sum keeps its carry, so a wrap past 24 bits still kills.
      age_sum = {1'b0, s.age} + {9'b0, step_dt};
      if (age_sum >= {1'b0, max_age} || $signed(s.alpha) <= 0) return r;

      fac = (wide_type'(1) <<< 32) - wide_type'(drag_coef) * dt;
      p[0] = wide_type'($signed(s.pos_x));
      p[1] = wide_type'($signed(s.pos_y));
      p[2] = wide_type'($signed(s.pos_z));
      v[0] = wide_type'($signed(s.vel_x));
      v[1] = wide_type'($signed(s.vel_y));
      v[2] = wide_type'($signed(s.vel_z));
      for (int k = 0; k < 3; k++) begin
         g    = wide_type'($signed(accel_xyz[16*k +: 16]));
         v[k] = clamp(v[k] + round_shift(g * dt, 8), 32);
         v[k] = clamp(round_shift(v[k] * fac, 32), 32);
         p[k] = clamp(p[k] + round_shift(v[k] * dt, 16), 32);
      end

      // Ground plane: reflect y velocity, damp x velocity, park just above y = 0.
      if (ground_on && p[1] < 0) begin
         v[1] = clamp(round_shift(-(v[1] * wide_type'(restitution)), 14), 32);
         v[0] = clamp(round_shift(v[0] * wide_type'(EIGHT_TENTHS_Q16), 16), 32);
         p[1] = wide_type'(GROUND_Y_Q16);
      end

      c[0] = wide_type'($signed(s.red));
      c[1] = wide_type'($signed(s.green));
      c[2] = wide_type'($signed(s.blue));
      c[3] = wide_type'($signed(s.alpha));
      for (int k = 0; k < 4; k++) begin
         rate = wide_type'($signed(fade_rgba[16*k +: 16]));
         c[k] = clamp(c[k] + round_shift(rate * dt, 16), 16);
      end
      g = clamp(wide_type'($signed(s.extent))
                + round_shift(wide_type'($signed(grow_rate)) * dt, 16), 16);

      r.alive  = 1'b1;
      r.pos_x  = p[0][31:0];
      r.pos_y  = p[1][31:0];
      r.pos_z  = p[2][31:0];
      r.vel_x  = v[0][31:0];
      r.vel_y  = v[1][31:0];
      r.vel_z  = v[2][31:0];
      r.extent = g[15:0];
      r.red    = c[0][15:0];
      r.green  = c[1][15:0];
      r.blue   = c[2][15:0];
      r.alpha  = c[3][15:0];
      return r;
   endfunction

   // Any bit pattern at all, dead or alive.
   function automatic particle_type noise_particle();
      logic [319:0] bits;
      bits = {$urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom, $urandom};
      return bits[295:0];
   endfunction

   // A particle that survives the frame when the lifetime exceeds dt, hovering
   // near the ground with moderate speed; now and then a full-range y velocity.
   function automatic particle_type live_particle();
      particle_type s;
      s = noise_particle();
      s.pos_y = int'($urandom_range(1048576)) - 524288;
      s.vel_x = int'($urandom_range(2621440)) - 1310720;
      s.vel_y = int'($urandom_range(2621440)) - 1310720;
      s.vel_z = int'($urandom_range(2621440)) - 1310720;
      if ($urandom_range(7) == 0) s.vel_y = $urandom;
      s.alpha = 16'($urandom_range(32767, 1));
      if (max_age > step_dt) s.age = 24'($urandom_range(max_age - step_dt - 1));
      return s;
   endfunction

   // Write one register; fill bits above its width with junk the block must drop.
   task automatic write_reg(csr_idx_type idx, logic [63:0] val);
      logic [63:0] mask, data;
      case (idx)
         REG_FRAME_DT: begin
            mask = 64'hFFFF;          step_dt = val[15:0];
         end
         REG_LIFETIME: begin
            mask = 64'hFF_FFFF;       max_age = val[23:0];
         end
         REG_GRAVITY: begin
            mask = 64'hFFFF_FFFF_FFFF; accel_xyz = val[47:0];
         end
         REG_DRAG: begin
            mask = 64'hFFFF;          drag_coef = val[15:0];
         end
         REG_BOUNCE: begin
            mask = 64'hFFFF;          restitution = val[15:0];
         end
         REG_COLLISION: begin
            mask = 64'h1;             ground_on = val[0];
         end
         REG_SIZE_GROW: begin
            mask = 64'hFFFF;          grow_rate = val[15:0];
         end
         default: begin
            mask = '1;                fade_rgba = val;
         end
      endcase
      data = ({$urandom, $urandom} & ~mask) | (val & mask);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_idx   <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Hold until every queued particle is accepted and every result is back.
   task automatic wait_idle();
      while (pending_particles.size() != 0 || req_valid || predicted_states.size() != 0)
         @(posedge clock);
   endtask

   // Driver: predict at acceptance, then advance to the next pending beat or
   // idle. Valid stays up with a frozen payload until the beat is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            predicted_states = {predicted_states, advance_particle(beat)};
         if (!req_valid || req_ready) begin
            if (pending_particles.size() != 0 && (steady || $urandom_range(99) >= 9)) begin
               req_valid <= 1'b1;
               beat      <= pending_particles.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each result beat with the oldest prediction, and stall
   // the result side at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{alive: rsp_alive, pos_x: rsp_pos_x, pos_y: rsp_pos_y, pos_z: rsp_pos_z,
                    vel_x: rsp_vel_x, vel_y: rsp_vel_y, vel_z: rsp_vel_z,
                    extent: rsp_extent, red: rsp_red, green: rsp_green,
                    blue: rsp_blue, alpha: rsp_alpha};
            if (predicted_states.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%t: result beat with no particle outstanding: %p", $time, got);
            end else begin
               want = predicted_states.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%t: particle result mismatch", $time);
                     $display("   expected %p", want);
                     $display("   actual   %p", got);
                  end
               end
            end
         end
         rsp_ready <= steady || ($urandom_range(99) >= 9);
      end
   end

   // Stimulus and end of run.
   initial begin
      particle_type s;
      logic [63:0]  regval[8];

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // A few particles under the reset settings.
      for (int i = 0; i < 3; i++) pending_particles = {pending_particles, live_particle()};
      wait_idle();

      // Typical frame: 1/60 s, mild drag, bounce 0.7, rates of both signs.
      regval[REG_FRAME_DT]   = 64'd1092;
      regval[REG_LIFETIME]   = 64'd327680;
      regval[REG_GRAVITY]    = 64'hFF80_F631_0100;
      regval[REG_DRAG]       = 64'h1999;
      regval[REG_BOUNCE]     = 64'd11469;
      regval[REG_COLLISION]  = 64'd1;
      regval[REG_SIZE_GROW]  = 64'h0200;
      regval[REG_COLOR_FADE] = 64'h8000_7FFF_C000_4000;
      for (int i = 0; i < 8; i++) write_reg(csr_idx_type'(i), regval[i]);

      // Directed particles: alpha and age edges of death, ground hits,
      // saturation of every field both ways.
      for (int d = 0; d < 20; d++) begin
         s = live_particle();
         case (d)
            1:  s.alpha = 16'h0000;
            2:  s.alpha = 16'hFFFF;
            3:  s.alpha = 16'h0001;
            4:  s.alpha = 16'h8000;
            5:  s.alpha = 16'h7FFF;
            6:  s.age = max_age - step_dt - 1;
            7:  s.age = max_age - step_dt;
            8:  s.age = 24'hFF_FFFF;
            9:  begin s.pos_y = 0; s.vel_y = 0; end
            10: begin s.pos_y = 32'sh1000; s.vel_y = -32'sd3000000; end
            11: begin
               s.pos_x = 32'h7FFF_FFFF; s.pos_y = 32'h7FFF_FFFF; s.pos_z = 32'h7FFF_FFFF;
               s.vel_x = 32'h7FFF_FFFF; s.vel_y = 32'h7FFF_FFFF; s.vel_z = 32'h7FFF_FFFF;
            end
            12: begin
               s.pos_x = 32'h8000_0000; s.pos_y = 32'h8000_0000; s.pos_z = 32'h8000_0000;
               s.vel_x = 32'h8000_0000; s.vel_y = 32'h8000_0000; s.vel_z = 32'h8000_0000;
            end
            13: begin s.pos_y = 32'h8000_0000; s.vel_y = 0; end
            14: begin
               s.extent = 16'h7FFF; s.red = 16'h7FFF; s.green = 16'h7FFF;
               s.blue = 16'h7FFF; s.alpha = 16'h7FFF;
            end
            15: begin
               s.extent = 16'h8000; s.red = 16'h8000; s.green = 16'h8000;
               s.blue = 16'h8000; s.alpha = 16'h0001;
            end
            16: begin s.vel_x = 32'h8000_0000; s.pos_y = -32'sd65536; end
            17: begin s.age = '0; s.pos_x = 0; s.pos_y = 0; s.vel_x = 0; s.vel_z = 0; end
            18: s = noise_particle();
            19: begin s.vel_y = 32'h7FFF_FFFF; s.pos_y = -32'sd1; end
            default: ;
         endcase
         pending_particles = {pending_particles, s};
      end
      wait_idle();

      // Random phases: phase 1 pushes every setting to its top, phase 2 all but dt
      // and lifetime to the bottom; the rest are random. Phase 4 runs without idling.
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            1: begin
               regval[REG_FRAME_DT]   = 64'hFFFF;
               regval[REG_LIFETIME]   = 64'hFF_FFFF;
               regval[REG_GRAVITY]    = 64'h7FFF_7FFF_7FFF;
               regval[REG_DRAG]       = 64'hFFFF;
               regval[REG_BOUNCE]     = 64'hFFFF;
               regval[REG_COLLISION]  = 64'd1;
               regval[REG_SIZE_GROW]  = 64'h7FFF;
               regval[REG_COLOR_FADE] = 64'h7FFF_7FFF_7FFF_7FFF;
            end
            2: begin
               regval[REG_FRAME_DT]   = 64'hFFFF;
               regval[REG_LIFETIME]   = 64'hFF_FFFF;
               regval[REG_GRAVITY]    = 64'h8000_8000_8000;
               regval[REG_DRAG]       = 64'h0;
               regval[REG_BOUNCE]     = 64'h0;
               regval[REG_COLLISION]  = 64'd0;
               regval[REG_SIZE_GROW]  = 64'h8000;
               regval[REG_COLOR_FADE] = 64'h8000_8000_8000_8000;
            end
            default: begin
               case ($urandom_range(3))
                  0:       regval[REG_FRAME_DT] = 64'($urandom_range(65535));
                  1:       regval[REG_FRAME_DT] = 64'($urandom_range(4096));
                  2:       regval[REG_FRAME_DT] = 64'd0;
                  default: regval[REG_FRAME_DT] = 64'hFFFF;
               endcase
               regval[REG_LIFETIME]   = ($urandom_range(7) == 0) ? 64'd0 : 64'($urandom);
               regval[REG_GRAVITY]    = {$urandom, $urandom};
               regval[REG_DRAG]       = 64'($urandom);
               regval[REG_BOUNCE]     = 64'($urandom);
               regval[REG_COLLISION]  = ($urandom_range(3) != 0) ? 64'd1 : 64'd0;
               regval[REG_SIZE_GROW]  = 64'($urandom);
               regval[REG_COLOR_FADE] = {$urandom, $urandom};
            end
         endcase
         for (int i = 0; i < 8; i++) write_reg(csr_idx_type'(i), regval[i]);

         steady = (phase == 4);
         for (int n = 0; n < 90; n++)
            pending_particles = {pending_particles,
                                 (($urandom_range(4) == 0) ? noise_particle()
                                                           : live_particle())};
         wait_idle();
         steady = 1'b0;
      end

      // Drain the six-stage pipe with margin before the verdict.
      repeat (12) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   // Watchdog: a run that hangs is reported NOT OK.
   initial begin
      #100us;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
design/peu_pkg.sv
design/particle_euler_update.sv
bench/tb_top.sv
